// ===== rtl/pcf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcf_pkg: shared types and constants of the PNG chunk framer
// Input opcodes, the command word passed from the front end to the back end,
// byte-step markers of the back end sequencer and the byte-wise CRC-32 update.
// ----------------------------------------------------------------------------
package pcf_pkg;

  localparam int unsigned LEN_W   = 31;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned STEP_W  = 4;
  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
  localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

  localparam logic [WORD_W-1:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [WORD_W-1:0] CRC_ONES = 32'hFFFF_FFFF;

  // Byte steps of one command: 0..3 length, 4..7 type, 8..11 CRC.
  // Data and misuse commands enter at the body step and skip the header.
  localparam logic [STEP_W-1:0] STEP_LEN0     = 4'd0;
  localparam logic [STEP_W-1:0] STEP_TYPE0    = 4'd4;
  localparam logic [STEP_W-1:0] STEP_BODY     = 4'd7;
  localparam logic [STEP_W-1:0] STEP_CRC0     = 4'd8;
  localparam logic [STEP_W-1:0] STEP_CRC_LAST = 4'd11;

  typedef enum logic {
    OP_START = 1'b0,
    OP_DATA  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    KIND_MISUSE = 2'd0,
    KIND_START  = 2'd1,
    KIND_DATA   = 2'd2
  } kind_e;

  // Command from front end to back end
  typedef struct packed {
    kind_e               kind;
    logic                tail;  // CRC trailer follows
    logic [LEN_W-1:0]    len;   // chunk length (start only)
    logic [WORD_W-1:0]   word;  // type bytes, or data byte in the low lane
  } cmd_t;

  // One byte through the reflected CRC-32 register
  function automatic logic [WORD_W-1:0] crc_feed(logic [WORD_W-1:0] c,
                                                 logic [BYTE_W-1:0] b);
    logic [WORD_W-1:0] r;
    r = c ^ {{(WORD_W-BYTE_W){1'b0}}, b};
    for (int k = 0; k < BYTE_W; k++) begin
      r = r[0] ? (CRC_POLY ^ (r >> 1)) : (r >> 1);
    end
    return r;
  endfunction

endpackage

// ===== rtl/pcf_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcf_in_if: input item channel
// Valid/ready channel carrying one start or data item per transfer.
// ----------------------------------------------------------------------------
interface pcf_in_if;
  import pcf_pkg::*;

  logic              valid;
  logic              ready;
  logic              opcode;
  logic [LEN_W-1:0]  chunk_length;
  logic [WORD_W-1:0] chunk_type;
  logic [BYTE_W-1:0] data_byte;

  modport source (output valid, opcode, chunk_length, chunk_type, data_byte,
                  input ready);
  modport sink   (input valid, opcode, chunk_length, chunk_type, data_byte,
                  output ready);
endinterface

// ===== rtl/pcf_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcf_out_if: framed byte channel
// Valid/ready channel carrying one stream byte and its flags per transfer.
// ----------------------------------------------------------------------------
interface pcf_out_if;
  import pcf_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              run_last;
  logic              chunk_end;
  logic              misuse;

  modport source (output valid, out_byte, run_last, chunk_end, misuse,
                  input ready);
  modport sink   (input valid, out_byte, run_last, chunk_end, misuse,
                  output ready);
endinterface

// ===== rtl/pcf_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcf_front: item classifier
// Tracks whether a chunk is open and how many data bytes remain, and turns
// each accepted item into a start, data or misuse command.
// ----------------------------------------------------------------------------
module pcf_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  pcf_in_if.sink        in_i,
  output logic          push_valid_o,
  output pcf_pkg::cmd_t push_cmd_o,
  input  logic          push_ready_i
);
  import pcf_pkg::*;

  logic             open_q, open_d;
  logic [LEN_W-1:0] left_q, left_d;
  logic             xfer;
  logic             last_data;

  assign in_i.ready   = push_ready_i;
  assign push_valid_o = in_i.valid;
  assign xfer         = in_i.valid && push_ready_i;
  assign last_data    = (left_q == {{(LEN_W-1){1'b0}}, 1'b1});

  // Classify the item and update chunk state on transfer
  always_comb begin
    push_cmd_o = '{kind: KIND_MISUSE, tail: 1'b0, len: '0, word: '0};
    open_d     = open_q;
    left_d     = left_q;
    if (op_e'(in_i.opcode) == OP_START) begin
      if (!open_q) begin
        push_cmd_o.kind = KIND_START;
        push_cmd_o.tail = (in_i.chunk_length == '0);
        push_cmd_o.len  = in_i.chunk_length;
        push_cmd_o.word = in_i.chunk_type;
        if (xfer && (in_i.chunk_length != '0)) begin
          open_d = 1'b1;
          left_d = in_i.chunk_length;
        end
      end
    end else begin
      if (open_q) begin
        push_cmd_o.kind = KIND_DATA;
        push_cmd_o.tail = last_data;
        push_cmd_o.word = {{(WORD_W-BYTE_W){1'b0}}, in_i.data_byte};
        if (xfer) begin
          left_d = left_q - {{(LEN_W-1){1'b0}}, 1'b1};
          if (last_data) begin
            open_d = 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= 1'b0;
      left_q <= '0;
    end else begin
      open_q <= open_d;
      left_q <= left_d;
    end
  end

endmodule

// ===== rtl/pcf_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcf_queue: command queue
// Small register FIFO between front end and back end.
// ----------------------------------------------------------------------------
module pcf_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  input  pcf_pkg::cmd_t push_cmd_i,
  output logic          push_ready_o,
  output logic          pop_valid_o,
  output pcf_pkg::cmd_t pop_cmd_o,
  input  logic          pop_ready_i
);
  import pcf_pkg::*;

  cmd_t               mem_q [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [Q_CNT_W-1:0] cnt_q, cnt_d;
  logic               push, pop;

  assign push_ready_o = (cnt_q != Q_CNT_W'(Q_DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_cmd_o    = mem_q[rd_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // Pointer and fill count update
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push) begin
      wr_d = (wr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop) begin
      rd_d = (rd_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Entry storage, no reset
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_cmd_i;
    end
  end

endmodule

// ===== rtl/pcf_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcf_back: byte sequencer
// Steps through the bytes of each command, runs the CRC over type and data
// bytes and drives the registered output stage.
// ----------------------------------------------------------------------------
module pcf_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          pop_valid_i,
  input  pcf_pkg::cmd_t pop_cmd_i,
  output logic          pop_ready_o,
  pcf_out_if.source     out_o
);
  import pcf_pkg::*;

  cmd_t              cur_q, cur_d;
  logic              cur_valid_q, cur_valid_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [WORD_W-1:0] crc_q, crc_d;
  logic              out_valid_q, out_valid_d;
  logic [BYTE_W-1:0] out_byte_q, out_byte_d;
  logic              run_last_q, run_last_d;
  logic              chunk_end_q, chunk_end_d;
  logic              misuse_q, misuse_d;

  logic              adv, emit, is_last, take;
  logic [STEP_W-1:0] last_step;
  logic [WORD_W-1:0] lane_word;
  logic [BYTE_W-1:0] cur_byte;

  assign adv       = !out_valid_q || out_o.ready;
  assign emit      = adv && cur_valid_q;
  assign last_step = cur_q.tail ? STEP_CRC_LAST : STEP_BODY;
  assign is_last   = (step_q == last_step);
  assign pop_ready_o = adv && (!cur_valid_q || is_last);
  assign take      = pop_ready_o && pop_valid_i;

  // Byte for the current step: length, type/data, then inverted CRC
  always_comb begin
    if (step_q < STEP_TYPE0) begin
      lane_word = {1'b0, cur_q.len};
    end else if (step_q < STEP_CRC0) begin
      lane_word = cur_q.word;
    end else begin
      lane_word = ~crc_q;
    end
    case (step_q[1:0])
      2'd0:    cur_byte = lane_word[31:24];
      2'd1:    cur_byte = lane_word[23:16];
      2'd2:    cur_byte = lane_word[15:8];
      default: cur_byte = lane_word[7:0];
    endcase
  end

  // Command register, step counter and CRC
  always_comb begin
    cur_d       = cur_q;
    cur_valid_d = cur_valid_q;
    step_d      = step_q;
    crc_d       = crc_q;
    if (emit && (cur_q.kind != KIND_MISUSE) &&
        (step_q >= STEP_TYPE0) && (step_q < STEP_CRC0)) begin
      crc_d = crc_feed((step_q == STEP_TYPE0) ? CRC_ONES : crc_q, cur_byte);
    end
    if (take) begin
      cur_d       = pop_cmd_i;
      cur_valid_d = 1'b1;
      step_d      = (pop_cmd_i.kind == KIND_START) ? STEP_LEN0 : STEP_BODY;
    end else if (emit && is_last) begin
      cur_valid_d = 1'b0;
    end else if (emit) begin
      step_d = step_q + 1'b1;
    end
  end

  // Output register
  always_comb begin
    out_valid_d = out_valid_q;
    out_byte_d  = out_byte_q;
    run_last_d  = run_last_q;
    chunk_end_d = chunk_end_q;
    misuse_d    = misuse_q;
    if (adv) begin
      out_valid_d = cur_valid_q;
    end
    if (emit) begin
      out_byte_d  = cur_byte;
      run_last_d  = is_last;
      chunk_end_d = (step_q == STEP_CRC_LAST);
      misuse_d    = (cur_q.kind == KIND_MISUSE);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      step_q      <= STEP_LEN0;
      crc_q       <= CRC_ONES;
      out_valid_q <= 1'b0;
    end else begin
      cur_valid_q <= cur_valid_d;
      step_q      <= step_d;
      crc_q       <= crc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q       <= cur_d;
    out_byte_q  <= out_byte_d;
    run_last_q  <= run_last_d;
    chunk_end_q <= chunk_end_d;
    misuse_q    <= misuse_d;
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.out_byte  = out_byte_q;
  assign out_o.run_last  = run_last_q;
  assign out_o.chunk_end = chunk_end_q;
  assign out_o.misuse    = misuse_q;

endmodule

// ===== rtl/png_chunk_framer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// png_chunk_framer: PNG chunk framer with CRC-32
// Frames start and data items into a PNG chunk byte stream.
//
//   channel | dir | payload                                       | transfer
//   in_i    | in  | opcode, chunk_length, chunk_type, data_byte   | one item
//   out_o   | out | out_byte, run_last, chunk_end, misuse         | one byte
//
// The back end sequencer gives one output byte per cycle unless the output
// stalls: a data item gives one byte (five when it closes the chunk), a start
// eight (twelve for a zero-length chunk), a misuse item one. An item passes a
// two-entry command queue and the command register before its first byte is
// valid in the output register; input ready drops only when the queue is full.
// Reset clears the chunk state and the queue; no clearing pass.
// ----------------------------------------------------------------------------
module png_chunk_framer (
  input  logic      clk_i,
  input  logic      rst_ni,
  pcf_in_if.sink    in_i,
  pcf_out_if.source out_o
);
  import pcf_pkg::*;

  logic push_valid, push_ready;
  cmd_t push_cmd;
  logic pop_valid, pop_ready;
  cmd_t pop_cmd;

  pcf_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .push_valid_o (push_valid),
    .push_cmd_o   (push_cmd),
    .push_ready_i (push_ready)
  );

  pcf_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_cmd_i   (push_cmd),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_cmd_o    (pop_cmd),
    .pop_ready_i  (pop_ready)
  );

  pcf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_cmd_i   (pop_cmd),
    .pop_ready_o (pop_ready),
    .out_o       (out_o)
  );

  // Every input transfer lands in the queue
  a_in_to_queue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |-> (push_valid && push_ready))
    else $error("input transfer not queued");

  // Last CRC byte always ends its item and is never a misuse result
  a_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.chunk_end) |-> (out_o.run_last && !out_o.misuse))
    else $error("chunk end without run_last");

  // A misuse result is the only result of its item
  a_misuse_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.misuse) |-> (out_o.run_last && (out_o.out_byte == '0)))
    else $error("bad misuse result");

  // After a start command pops, a stalled output byte does not turn into a chunk end
  a_pop_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_valid && pop_ready && (pop_cmd.kind == KIND_START)) |=>
      !(out_o.valid && out_o.chunk_end && !$past(out_o.ready) && $past(out_o.valid)
        && !$past(out_o.chunk_end)))
    else $error("output changed while stalled");

endmodule

// ===== tb/sv/png_chunk_framer_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// png_chunk_framer_tb: self-checking testbench of the PNG chunk framer
// Drives start and data items into the framer with random gaps and stalls.
// A predictor rebuilds the framed byte stream, including the length and type
// header, the running CRC-32 trailer and the misuse flags. Every output
// transfer is compared against the oldest predicted byte.
// ----------------------------------------------------------------------------
module png_chunk_framer_tb;
  import pcf_pkg::*;

  localparam int unsigned CLK_PERIOD   = 12;
  localparam int unsigned RESET_CYCLES = 8;
  localparam int unsigned GOOD_ITEMS   = 120;
  localparam int unsigned DRAIN_CYCLES = 24;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned MAX_REPORTS  = 10;

  localparam logic [LEN_W-1:0]  LEN_MAX   = '1;
  localparam logic [WORD_W-1:0] TYPE_IEND = 32'h4945_4E44;
  localparam logic [WORD_W-1:0] TYPE_IDAT = 32'h4944_4154;
  localparam logic [WORD_W-1:0] TYPE_IHDR = 32'h4948_4452;
  localparam logic [WORD_W-1:0] TYPE_TEXT = 32'h7445_5874;

  // One byte of the framed stream with its flags
  typedef struct packed {
    logic [BYTE_W-1:0] value;
    logic              run_last;
    logic              chunk_end;
    logic              misuse;
  } frame_byte_t;

  // Predicts the framed stream and checks each output transfer against it
  class chunk_frame_predictor;
    logic [WORD_W-1:0] crc_reg    = CRC_ONES;
    logic [LEN_W-1:0]  bytes_left = '0;
    bit                chunk_open = 1'b0;
    frame_byte_t       pending_bytes[$];
    frame_byte_t       burst[$];
    int unsigned       fault_count = 0;

    // Reflected CRC-32, one input bit at a time
    function logic [WORD_W-1:0] crc_byte(logic [WORD_W-1:0] c, logic [BYTE_W-1:0] b);
      logic fb;
      for (int i = 0; i < BYTE_W; i++) begin
        fb = c[0] ^ b[i];
        c  = c >> 1;
        if (fb) c = c ^ CRC_POLY;
      end
      return c;
    endfunction

    function void put_byte(logic [BYTE_W-1:0] v, logic cend, logic bad);
      frame_byte_t r;
      r.value     = v;
      r.run_last  = 1'b0;
      r.chunk_end = cend;
      r.misuse    = bad;
      burst.push_back(r);
    endfunction

    // Inverted CRC, most significant byte first
    function void put_crc();
      logic [WORD_W-1:0] v;
      v = crc_reg ^ CRC_ONES;
      put_byte(v[31:24], 1'b0, 1'b0);
      put_byte(v[23:16], 1'b0, 1'b0);
      put_byte(v[15:8],  1'b0, 1'b0);
      put_byte(v[7:0],   1'b1, 1'b0);
    endfunction

    // Called once per accepted input transfer
    function void note_item(op_e op, logic [LEN_W-1:0] len, logic [WORD_W-1:0] ctype,
                            logic [BYTE_W-1:0] db);
      frame_byte_t r;
      burst.delete();
      if (op == OP_START) begin
        if (chunk_open) begin
          put_byte('0, 1'b0, 1'b1);
        end else begin
          put_byte({1'b0, len[30:24]}, 1'b0, 1'b0);
          put_byte(len[23:16], 1'b0, 1'b0);
          put_byte(len[15:8],  1'b0, 1'b0);
          put_byte(len[7:0],   1'b0, 1'b0);
          crc_reg = CRC_ONES;
          for (int s = 3; s >= 0; s--) begin
            put_byte(ctype[s*8 +: 8], 1'b0, 1'b0);
            crc_reg = crc_byte(crc_reg, ctype[s*8 +: 8]);
          end
          if (len == '0) begin
            put_crc();
          end else begin
            bytes_left = len;
            chunk_open = 1'b1;
          end
        end
      end else begin
        if (!chunk_open) begin
          put_byte('0, 1'b0, 1'b1);
        end else begin
          put_byte(db, 1'b0, 1'b0);
          crc_reg    = crc_byte(crc_reg, db);
          bytes_left = bytes_left - 1'b1;
          if (bytes_left == '0) begin
            put_crc();
            chunk_open = 1'b0;
          end
        end
      end
      // run_last marks the final byte caused by this item
      foreach (burst[i]) begin
        r = burst[i];
        r.run_last = (i == burst.size() - 1);
        pending_bytes.push_back(r);
      end
    endfunction

    // Called once per accepted output transfer
    function void check_byte(frame_byte_t got);
      frame_byte_t want;
      if (pending_bytes.size() == 0) begin
        if (fault_count < MAX_REPORTS)
          $display("%0t: unexpected byte %02h last=%0b end=%0b misuse=%0b", $time,
                   got.value, got.run_last, got.chunk_end, got.misuse);
        fault_count++;
        return;
      end
      want = pending_bytes.pop_front();
      if (got.value !== want.value || got.run_last !== want.run_last ||
          got.chunk_end !== want.chunk_end || got.misuse !== want.misuse) begin
        if (fault_count < MAX_REPORTS)
          $display("%0t: byte mismatch: expected %02h/%0b/%0b/%0b, got %02h/%0b/%0b/%0b",
                   $time, want.value, want.run_last, want.chunk_end, want.misuse,
                   got.value, got.run_last, got.chunk_end, got.misuse);
        fault_count++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  pcf_in_if  in_ch ();
  pcf_out_if out_ch ();

  png_chunk_framer dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_ch.sink),
    .out_o  (out_ch.source)
  );

  chunk_frame_predictor frame_model;

  int unsigned in_stretch  = 0;
  bit          in_idling   = 1'b0;
  int unsigned out_stretch = 0;
  bit          out_idling  = 1'b0;
  int unsigned quiet_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Wait cycles come in stretches: some with random gaps, some with none
  function automatic int unsigned draw_wait(inout int unsigned left, inout bit idling);
    if (left == 0) begin
      left   = $urandom_range(8, 40);
      idling = ($urandom_range(0, 3) != 0);
    end
    left--;
    return idling ? $urandom_range(0, 15) : 0;
  endfunction

  // One input transfer; valid stays high into the next item when there is no gap
  task automatic send_item(op_e op, logic [LEN_W-1:0] len, logic [WORD_W-1:0] ctype,
                           logic [BYTE_W-1:0] db);
    int unsigned gap;
    gap = draw_wait(in_stretch, in_idling);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.opcode       <= op;
    in_ch.chunk_length <= len;
    in_ch.chunk_type   <= ctype;
    in_ch.data_byte    <= db;
    do @(posedge clk); while (!in_ch.ready);
    frame_model.note_item(op, len, ctype, db);
  endtask

  // A well-formed chunk; noisy ones slip in starts while the chunk is open
  task automatic send_chunk(logic [LEN_W-1:0] len, logic [WORD_W-1:0] ctype, bit noisy);
    send_item(OP_START, len, ctype, BYTE_W'($urandom_range(0, 255)));
    for (int unsigned i = 0; i < len; i++) begin
      if (noisy && $urandom_range(0, 9) == 0)
        send_item(OP_START, LEN_W'($urandom), $urandom, BYTE_W'($urandom_range(0, 255)));
      send_item(OP_DATA, LEN_W'($urandom), $urandom, BYTE_W'($urandom_range(0, 255)));
    end
  endtask

  // Output side: random stalls, check every transfer
  initial begin
    int unsigned stall;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      stall = draw_wait(out_stretch, out_idling);
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      frame_model.check_byte({out_ch.out_byte, out_ch.run_last, out_ch.chunk_end,
                              out_ch.misuse});
    end
  end

  // Watchdog: too long without any transfer ends the run
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("png_chunk_framer_tb: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int unsigned good_items;
    int unsigned len;
    frame_model = new();
    good_items  = 0;
    rst_n              <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.opcode       <= OP_START;
    in_ch.chunk_length <= '0;
    in_ch.chunk_type   <= '0;
    in_ch.data_byte    <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: misuse both ways, zero-length chunks, short chunks
    send_item(OP_DATA, '0, '0, 8'hFF);
    send_item(OP_START, '0, TYPE_IEND, 8'h00);
    send_item(OP_START, '0, '1, 8'hFF);
    send_item(OP_START, '0, '0, 8'h00);
    send_item(OP_START, 31'd1, TYPE_IDAT, 8'h00);
    send_item(OP_DATA, '0, '0, 8'h00);
    send_item(OP_START, 31'd3, TYPE_IHDR, 8'h00);
    send_item(OP_START, LEN_MAX, '1, 8'hFF);
    send_item(OP_DATA, LEN_MAX, '1, 8'hFF);
    send_item(OP_DATA, '0, '0, 8'h00);
    send_item(OP_DATA, '0, '0, 8'hA5);
    send_item(OP_DATA, LEN_MAX, '1, 8'h5A);
    send_chunk(31'd4, TYPE_TEXT, 1'b0);

    // Random: mostly chunks with random content, some stray data bytes
    while (good_items < GOOD_ITEMS) begin
      if ($urandom_range(0, 9) == 0) begin
        send_item(OP_DATA, LEN_W'($urandom), $urandom, BYTE_W'($urandom_range(0, 255)));
      end else begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 24) : $urandom_range(0, 6);
        send_chunk(LEN_W'(len), $urandom, 1'b1);
        good_items += len + 1;
      end
    end

    // Longest chunk last: it stays open to the end of the run
    send_item(OP_START, LEN_MAX, $urandom, BYTE_W'($urandom_range(0, 255)));
    repeat (3) send_item(OP_DATA, LEN_W'($urandom), $urandom,
                         BYTE_W'($urandom_range(0, 255)));
    send_item(OP_START, LEN_W'($urandom), $urandom, BYTE_W'($urandom_range(0, 255)));
    send_item(OP_DATA, LEN_W'($urandom), $urandom, BYTE_W'($urandom_range(0, 255)));
    in_ch.valid <= 1'b0;

    // Drain, then watch for stray bytes
    while (frame_model.pending_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (frame_model.fault_count == 0) begin
      $display("png_chunk_framer_tb: done, clean");
    end else begin
      $display("png_chunk_framer_tb: done, errors");
    end
    $finish;
  end

endmodule
